// ----- rtl/core/swsd_pkg.sv -----
`timescale 1ns / 1ps
package swsd_pkg;

  localparam int unsigned HundWidth  = 7;
  localparam int unsigned SecWidth   = 10;
  localparam int unsigned NumDigits  = 6;
  localparam int unsigned CountWidth = 3;

  // Commands
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_REFRESH = 2'd1,
    CMD_BLANK   = 2'd2,
    CMD_SHIFT   = 2'd3
  } cmd_e;

  // Shift-out sequencer states
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SHIFT = 1'b1
  } state_e;

  localparam logic [7:0] GlyphBlank = 8'hFF;
  localparam logic [7:0] DpMask     = 8'h7F;

  // Per-cell control: load a new byte, or take the neighbor's byte
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // Decimal digits of the running time
  typedef struct packed {
    logic [3:0] sec_hund;
    logic [3:0] sec_tens;
    logic [3:0] sec_unit;
    logic [3:0] hs_tens;
    logic [3:0] hs_unit;
  } time_digits_t;

  // Active-low seven-segment pattern, blank above nine
  function automatic logic [7:0] glyph_of(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'hC0;
      4'd1:    g = 8'hF9;
      4'd2:    g = 8'hA4;
      4'd3:    g = 8'hB0;
      4'd4:    g = 8'h99;
      4'd5:    g = 8'h92;
      4'd6:    g = 8'h82;
      4'd7:    g = 8'hF8;
      4'd8:    g = 8'h80;
      4'd9:    g = 8'h90;
      default: g = GlyphBlank;
    endcase
    return g;
  endfunction

  // Value mod 10 for an 8-bit value: quotient by reciprocal (x*205)>>11
  function automatic logic [3:0] mod10_u8(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  quo;
    logic [7:0]  rem;
    prod = 16'(v) * 16'd205;
    quo  = prod[15:11];
    rem  = v - 8'(quo) * 8'd10;
    return rem[3:0];
  endfunction

endpackage

// ----- rtl/core/swsd_cell.sv -----
`timescale 1ns / 1ps
module swsd_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swsd_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]           load_byte_i,
  input  logic [7:0]           prev_byte_i,
  output logic [7:0]           byte_o
);
  import swsd_pkg::*;

  logic [7:0] byte_q, byte_d;

  // Load wins; otherwise take the neighbor's byte on a shift
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.load) begin
      byte_d = load_byte_i;
    end else if (ctrl_i.shift) begin
      byte_d = prev_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

// ----- rtl/core/swsd_timer.sv -----
`timescale 1ns / 1ps
module swsd_timer #(
  parameter int unsigned TICKS_PER_SECOND = 100,
  parameter int unsigned SECONDS_WRAP     = 1000
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tick_i,
  output swsd_pkg::time_digits_t digits_o
);
  import swsd_pkg::*;

  localparam logic [HundWidth:0] HundLimit = (HundWidth + 1)'(TICKS_PER_SECOND);
  localparam logic [SecWidth:0]  SecLimit  = (SecWidth + 1)'(SECONDS_WRAP);

  logic [HundWidth-1:0] hund_q, hund_d;
  logic [SecWidth-1:0]  sec_q, sec_d;
  time_digits_t         dig_q, dig_d;
  logic [HundWidth:0]   hund_inc;
  logic [SecWidth:0]    sec_inc;

  assign hund_inc = {1'b0, hund_q} + 1'b1;
  assign sec_inc  = {1'b0, sec_q} + 1'b1;

  // Binary counters decide the wrap; decimal digits follow in step
  always_comb begin
    hund_d = hund_q;
    sec_d  = sec_q;
    dig_d  = dig_q;
    if (tick_i) begin
      if (hund_inc >= HundLimit) begin
        hund_d        = '0;
        dig_d.hs_tens = '0;
        dig_d.hs_unit = '0;
        if (sec_inc >= SecLimit) begin
          sec_d          = '0;
          dig_d.sec_hund = '0;
          dig_d.sec_tens = '0;
          dig_d.sec_unit = '0;
        end else begin
          sec_d = sec_inc[SecWidth-1:0];
          if (dig_q.sec_unit == 4'd9) begin
            dig_d.sec_unit = '0;
            if (dig_q.sec_tens == 4'd9) begin
              dig_d.sec_tens = '0;
              dig_d.sec_hund = dig_q.sec_hund + 4'd1;
            end else begin
              dig_d.sec_tens = dig_q.sec_tens + 4'd1;
            end
          end else begin
            dig_d.sec_unit = dig_q.sec_unit + 4'd1;
          end
        end
      end else begin
        hund_d = hund_inc[HundWidth-1:0];
        if (dig_q.hs_unit == 4'd9) begin
          dig_d.hs_unit = '0;
          dig_d.hs_tens = dig_q.hs_tens + 4'd1;
        end else begin
          dig_d.hs_unit = dig_q.hs_unit + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hund_q <= '0;
      sec_q  <= '0;
      dig_q  <= '0;
    end else begin
      hund_q <= hund_d;
      sec_q  <= sec_d;
      dig_q  <= dig_d;
    end
  end

  assign digits_o = dig_q;

  // Counters stay below their limits
  assert property (@(posedge clk_i) disable iff (!rst_ni) {1'b0, hund_q} < HundLimit)
    else $error("hundredths counter out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) {1'b0, sec_q} < SecLimit)
    else $error("seconds counter out of range");
  // Both hundredths digits read zero whenever the binary count is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hund_q == '0) |-> (dig_q.hs_unit == '0 && dig_q.hs_tens == '0))
    else $error("hundredths digits out of step");

endmodule

// ----- rtl/core/stopwatch_seven_segment_display_unit.sv -----
`timescale 1ns / 1ps
// Tick, refresh and blank items are taken while idle and leave in_ready_o high.
// A shift-out item produces six result items, the first valid the cycle after acceptance,
// then one per cycle while out_ready_i is high.
// Bytes come from the six-cell byte ring, which rotates one place per delivered byte.
// No new item is taken until the last byte of a shift-out is delivered.
// Reset (rst_ni low, asynchronous) clears both counters and all six display bytes to zero.
module stopwatch_seven_segment_display_unit #(
  parameter int unsigned TICKS_PER_SECOND = 100,
  parameter int unsigned SECONDS_WRAP     = 1000
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] lap_count_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] segment_byte_o,
  output logic       last_byte_o
);
  import swsd_pkg::*;

  state_e                state_q, state_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic                  in_acc, out_acc, is_last;
  cmd_e                  cmd;
  time_digits_t          digits;
  cell_ctrl_t            cell_ctrl;
  logic [7:0]            load_val  [NumDigits];
  logic [7:0]            cell_byte [NumDigits];

  assign cmd     = cmd_e'(cmd_i);
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign is_last = (count_q == CountWidth'(NumDigits - 1));

  swsd_timer #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .SECONDS_WRAP    (SECONDS_WRAP)
  ) u_timer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (in_acc && cmd == CMD_TICK),
    .digits_o(digits)
  );

  // Load patterns: all blank on a blank item; else cell 5 is the lap digit, cell 0 the hundredths units
  always_comb begin
    if (cmd == CMD_BLANK) begin
      for (int k = 0; k < NumDigits; k++) begin
        load_val[k] = GlyphBlank;
      end
    end else begin
      load_val[5] = glyph_of(mod10_u8(lap_count_i));
      load_val[4] = glyph_of(digits.sec_hund);
      load_val[3] = glyph_of(digits.sec_tens);
      load_val[2] = glyph_of(digits.sec_unit) & DpMask;
      load_val[1] = glyph_of(digits.hs_tens);
      load_val[0] = glyph_of(digits.hs_unit);
    end
  end

  assign cell_ctrl.load  = in_acc && (cmd == CMD_REFRESH || cmd == CMD_BLANK);
  assign cell_ctrl.shift = out_acc;

  // Byte ring: each cell takes its lower neighbor, cell 0 takes cell 5
  for (genvar g = 0; g < NumDigits; g++) begin : g_cell
    swsd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .load_byte_i(load_val[g]),
      .prev_byte_i(cell_byte[(g + NumDigits - 1) % NumDigits]),
      .byte_o     (cell_byte[g])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && cmd == CMD_SHIFT) begin
          state_d = ST_SHIFT;
          count_d = '0;
        end
      end
      ST_SHIFT: begin
        if (out_acc) begin
          if (is_last) begin
            state_d = ST_IDLE;
          end
          count_d = count_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        out_valid_o = 1'b0;
      end
      ST_SHIFT: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  assign segment_byte_o = cell_byte[NumDigits-1];
  assign last_byte_o    = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Shift-out starts with the first byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd == CMD_SHIFT) |=> (out_valid_o && count_q == '0))
    else $error("shift-out did not start at first byte");
  // Last byte delivered returns to accepting items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_byte_o) |=> (in_ready_o && !out_valid_o))
    else $error("sequencer did not return to idle");
  // Byte counter never passes the last cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_q < CountWidth'(NumDigits)))
    else $error("byte counter out of range");
  // Cell 0 holds its byte while delivery is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(cell_byte[0]))
    else $error("buffer moved while stalled");

endmodule

// ----- tb/sv/stopwatch_seven_segment_display_unit_tb.sv -----
`timescale 1ns / 1ps
module stopwatch_seven_segment_display_unit_tb;
  import swsd_pkg::*;

  localparam int unsigned TicksPerSecond = 100;
  localparam int unsigned SecondsWrap    = 1000;
  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned MaxReports     = 10;
  localparam int unsigned DrainCycles    = 16;

  // Active-low digit patterns, decimal point in bit 7
  localparam logic [7:0] DigitSeg [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };
  localparam logic [7:0] SegBlank = 8'hFF;
  localparam logic [7:0] SegDpOn  = 8'h7F;

  typedef struct packed {
    logic [7:0] seg;
    logic       last;
  } seg_item_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [1:0] cmd_i       = CMD_TICK;
  logic [7:0] lap_count_i = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b1;
  logic [7:0] segment_byte_o;
  logic       last_byte_o;

  // Predicted stopwatch state
  logic [6:0] hund_q;
  logic [9:0] sec_q;
  logic [7:0] disp_q [6];

  seg_item_t   pending_bytes[$];
  int unsigned mismatch_cnt  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles  = 0;

  stopwatch_seven_segment_display_unit #(
    .TICKS_PER_SECOND(TicksPerSecond),
    .SECONDS_WRAP    (SecondsWrap)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .lap_count_i   (lap_count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .segment_byte_o(segment_byte_o),
    .last_byte_o   (last_byte_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] digit_pattern(input int unsigned d);
    if (d > 9) begin
      return SegBlank;
    end
    return DigitSeg[d];
  endfunction

  // Advance the predicted stopwatch and queue any bytes the item shifts out
  task automatic predict_segment_bytes(input cmd_e c, input logic [7:0] lap);
    seg_item_t b;
    case (c)
      CMD_TICK: begin
        hund_q = hund_q + 7'd1;
        if (hund_q >= TicksPerSecond) begin
          hund_q = '0;
          sec_q  = sec_q + 10'd1;
          if (sec_q >= SecondsWrap) begin
            sec_q = '0;
          end
        end
      end
      CMD_REFRESH: begin
        disp_q[5] = digit_pattern(lap % 10);
        disp_q[4] = digit_pattern(sec_q / 100);
        disp_q[3] = digit_pattern((sec_q / 10) % 10);
        disp_q[2] = digit_pattern(sec_q % 10) & SegDpOn;
        disp_q[1] = digit_pattern(hund_q / 10);
        disp_q[0] = digit_pattern(hund_q % 10);
      end
      CMD_BLANK: begin
        for (int i = 0; i < 6; i++) begin
          disp_q[i] = SegBlank;
        end
      end
      default: begin
        for (int i = 5; i >= 0; i--) begin
          b.seg  = disp_q[i];
          b.last = (i == 0);
          pending_bytes.push_back(b);
        end
      end
    endcase
  endtask

  // Present one item, hold it until accepted, then predict
  task automatic send_item(input cmd_e c, input logic [7:0] lap);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    lap_count_i <= lap;
    do @(posedge clk_i); while (!in_ready_o);
    predict_segment_bytes(c, lap);
  endtask

  // Load the buffer from the running time and shift it out
  task automatic snapshot(input logic [7:0] lap);
    send_item(CMD_REFRESH, lap);
    send_item(CMD_SHIFT, 8'd0);
  endtask

  // Buffer holds zeros after reset; shifting twice leaves it unchanged
  task automatic test_reset_buffer();
    send_item(CMD_SHIFT, 8'd0);
    send_item(CMD_SHIFT, 8'd0);
  endtask

  // Blank, then refresh with lap extremes and digits around ten
  task automatic test_blank_and_refresh();
    send_item(CMD_BLANK, 8'd0);
    send_item(CMD_SHIFT, 8'd0);
    snapshot(8'd0);
    snapshot(8'd255);
    send_item(CMD_TICK, 8'd0);
    snapshot(8'd9);
    send_item(CMD_REFRESH, 8'd10);
    send_item(CMD_BLANK, 8'd170);
    send_item(CMD_SHIFT, 8'd85);
    send_item(CMD_REFRESH, 8'd128);
    send_item(CMD_SHIFT, 8'd127);
  endtask

  // Run the clock past a hundredths rollover into the next second
  task automatic test_counter_wrap();
    int unsigned total;
    total = TicksPerSecond + 5;
    for (int unsigned n = 1; n <= total; n++) begin
      send_item(CMD_TICK, 8'($urandom));
      if (n == TicksPerSecond - 1 || n == TicksPerSecond || n == total) begin
        snapshot(8'($urandom));
      end
    end
  endtask

  // Random mix of refresh-and-shift-out pairs, ticks, blanks, lone refreshes and lone shift-outs
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned pick;
    int unsigned sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        snapshot(8'($urandom));
        sent += 2;
      end else if (pick < 60) begin
        send_item(CMD_TICK, 8'($urandom));
        sent++;
      end else if (pick < 70) begin
        send_item(CMD_BLANK, 8'($urandom));
        sent++;
      end else if (pick < 80) begin
        send_item(CMD_REFRESH, 8'($urandom));
        sent++;
      end else begin
        send_item(CMD_SHIFT, 8'($urandom));
        sent++;
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each delivered byte with the oldest prediction
  always @(posedge clk_i) begin
    seg_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_bytes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports) begin
          $display("unexpected byte: seg=%h last=%b", segment_byte_o, last_byte_o);
        end
      end else begin
        want = pending_bytes.pop_front();
        if (segment_byte_o !== want.seg || last_byte_o !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports) begin
            $display("byte mismatch: expected seg=%h last=%b, got seg=%h last=%b",
                     want.seg, want.last, segment_byte_o, last_byte_o);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    hund_q = '0;
    sec_q  = '0;
    for (int i = 0; i < 6; i++) begin
      disp_q[i] = 8'h00;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_buffer();
    test_blank_and_refresh();
    test_counter_wrap();
    test_random_traffic(30, 0, 0);
    test_random_traffic(30, 50, 0);
    test_random_traffic(30, 0, 50);
    test_random_traffic(33, 6, 6);

    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
